// ===== sv/modular_inverse_defines.svh =====
// Assertion macros for the modular inverse block.
// Included by the top level; no other dependencies.
`ifndef MODULAR_INVERSE_DEFINES_SVH
`define MODULAR_INVERSE_DEFINES_SVH

`ifndef SYNTHESIS
`define MI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MI_ASSERT_IMP(lbl, ante, cons, msg)
`define MI_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/mi_pkg.sv =====
// Shared widths, sequencer states and status struct for the modular inverse.
// No dependencies.
package mi_pkg;

  localparam int DataW = 64;
  localparam int ModW  = 62;
  localparam int CntW  = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEG,
    ST_ALIGN,
    ST_DIV,
    ST_FIX,
    ST_CHECK,
    ST_UPDATE,
    ST_FIN_ABS,
    ST_FIN_SEL,
    ST_DONE
  } mi_state_e;

  typedef enum logic {
    PASS_REDUCE,
    PASS_EUCLID
  } mi_pass_e;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } mi_status_t;

endpackage

// ===== sv/mi_in_if.sv =====
// Input channel of the modular inverse: valid, ready and the signed value.
// Depends on mi_pkg.
interface mi_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [mi_pkg::DataW-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/mi_out_if.sv =====
// Output channel of the modular inverse: valid, ready and the inverse.
// Depends on mi_pkg.
interface mi_out_if;
  logic                       valid;
  logic                       ready;
  logic [mi_pkg::ModW-1:0]    inverse;

  modport source (output valid, output inverse, input ready);
  modport sink   (input valid, input inverse, output ready);
endinterface

// ===== sv/mi_sub.sv =====
// Shared 64-bit subtractor with borrow, used for most datapath compares and subtracts.
// Depends on mi_pkg.
module mi_sub (
  input  logic [mi_pkg::DataW-1:0] a_i,
  input  logic [mi_pkg::DataW-1:0] b_i,
  output logic [mi_pkg::DataW-1:0] diff_o,
  output logic                     borrow_o
);
  import mi_pkg::*;

  logic [DataW:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[DataW-1:0];
  assign borrow_o = full[DataW];
endmodule

// ===== sv/mi_core.sv =====
// Sequencer and datapath registers: residue reduction, extended Euclid by
// shift-subtract division, final coefficient reduction. Depends on mi_pkg, mi_sub.
module mi_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [mi_pkg::DataW-1:0] value_i,
  input  logic [mi_pkg::ModW-1:0]  modulus_i,
  input  logic                     res_ready_i,
  output mi_pkg::mi_status_t       status_o,
  output logic [mi_pkg::ModW-1:0]  inverse_o
);
  import mi_pkg::*;

  mi_state_e             state_q, state_d;
  mi_pass_e              pass_q, pass_d;
  logic [CntW-1:0]       k_q, k_d;
  logic                  neg_q, neg_d;
  logic [DataW-1:0]      rem_q, rem_d;
  logic [DataW-1:0]      d_q, d_d;
  logic [ModW-1:0]       rb_q, rb_d;
  logic [DataW-1:0]      ta_q, ta_d;
  logic [DataW-1:0]      tb_q, tb_d;
  logic [DataW-1:0]      p_q, p_d;
  logic [ModW-1:0]       inv_q, inv_d;

  logic [DataW-1:0]      sub_a, sub_b, sub_diff;
  logic                  sub_borrow;
  logic [DataW-1:0]      mod_ext;
  logic [DataW-1:0]      d_shl;
  logic [DataW-1:0]      res_fix;
  logic                  qbit;

  mi_sub u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  assign mod_ext = {{(DataW-ModW){1'b0}}, modulus_i};
  assign d_shl   = {d_q[DataW-2:0], 1'b0};
  assign qbit    = !sub_borrow;

  always_comb begin
    sub_a = rem_q;
    sub_b = d_q;
    unique case (state_q)
      ST_NEG, ST_FIN_ABS: begin
        sub_a = '0;
        sub_b = (state_q == ST_NEG) ? rem_q : ta_q;
      end
      ST_ALIGN: begin
        sub_b = d_shl;
      end
      ST_FIX, ST_FIN_SEL: begin
        sub_a = mod_ext;
        sub_b = rem_q;
      end
      ST_UPDATE: begin
        sub_a = ta_q;
        sub_b = p_q;
      end
      default: begin
        sub_a = rem_q;
        sub_b = d_q;
      end
    endcase
  end

  assign res_fix = (neg_q && (rem_q != '0)) ? sub_diff : rem_q;

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    k_d     = k_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    d_d     = d_q;
    rb_d    = rb_q;
    ta_d    = ta_q;
    tb_d    = tb_q;
    p_d     = p_q;
    inv_d   = inv_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rem_d = value_i;
          neg_d = value_i[DataW-1];
          if (modulus_i == '0) begin
            inv_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_NEG;
          end
        end
      end
      ST_NEG: begin
        if (neg_q) begin
          rem_d = sub_diff;
        end
        d_d     = mod_ext;
        k_d     = '0;
        pass_d  = PASS_REDUCE;
        state_d = ST_ALIGN;
      end
      ST_ALIGN: begin
        if (!d_q[DataW-1] && !sub_borrow) begin
          d_d = d_shl;
          k_d = k_q + CntW'(1);
        end else begin
          p_d     = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (qbit) begin
          rem_d = sub_diff;
        end
        d_d = {1'b0, d_q[DataW-1:1]};
        p_d = {p_q[DataW-2:0], 1'b0} + (qbit ? tb_q : '0);
        if (k_q == '0) begin
          state_d = (pass_q == PASS_REDUCE) ? ST_FIX : ST_UPDATE;
        end else begin
          k_d = k_q - CntW'(1);
        end
      end
      ST_FIX: begin
        rem_d   = mod_ext;
        d_d     = res_fix;
        rb_d    = res_fix[ModW-1:0];
        ta_d    = '0;
        tb_d    = DataW'(1);
        pass_d  = PASS_EUCLID;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        k_d     = '0;
        state_d = (rb_q == '0) ? ST_FIN_ABS : ST_ALIGN;
      end
      ST_UPDATE: begin
        tb_d    = sub_diff;
        ta_d    = tb_q;
        rem_d   = {{(DataW-ModW){1'b0}}, rb_q};
        d_d     = rem_q;
        rb_d    = rem_q[ModW-1:0];
        state_d = ST_CHECK;
      end
      ST_FIN_ABS: begin
        neg_d   = ta_q[DataW-1];
        rem_d   = ta_q[DataW-1] ? sub_diff : ta_q;
        state_d = ST_FIN_SEL;
      end
      ST_FIN_SEL: begin
        if (rem_q == mod_ext) begin
          inv_d = '0;
        end else if (neg_q) begin
          inv_d = sub_diff[ModW-1:0];
        end else begin
          inv_d = rem_q[ModW-1:0];
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= PASS_REDUCE;
      k_q     <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      k_q     <= k_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    d_q   <= d_d;
    rb_q  <= rb_d;
    ta_q  <= ta_d;
    tb_q  <= tb_d;
    p_q   <= p_d;
    inv_q <= inv_d;
  end

  assign status_o.busy      = (state_q != ST_IDLE);
  assign status_o.res_valid = (state_q == ST_DONE);
  assign inverse_o          = inv_q;
endmodule

// ===== sv/modular_inverse.sv =====
// Top level of the modular inverse: channels, modulus register, output register.
// Depends on mi_pkg, mi_in_if, mi_out_if, mi_core, modular_inverse_defines.svh.
//
//   channel   dir  payload                 transaction
//   in_i      in   value   signed 64 bits  valid && ready
//   out_o     out  inverse 62 bits         valid && ready
//   cfg       in   modulus 62 bits         cfg_we_i
//
// A transaction with modulus 0 goes straight to done. Otherwise each quotient bit passes
// through the shared subtractor (align, then divide), each Euclid step adds check and update,
// the 64-bit residue reduction comes first, and there are setup, final reduction and done states.
// in_i.ready is low from acceptance until the result moves into the output register.
// Reset clears the sequencer and output valid and sets the modulus to 2.
`include "modular_inverse_defines.svh"

module modular_inverse (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [mi_pkg::ModW-1:0] cfg_wdata_i,
  mi_in_if.sink                   in_i,
  mi_out_if.source                out_o
);
  import mi_pkg::*;

  logic [ModW-1:0] mod_q;
  logic            out_valid_q, out_valid_d;
  logic [ModW-1:0] out_inv_q;
  logic [ModW-1:0] core_inv;
  mi_status_t      core_status;
  logic            in_acc;
  logic            out_free;

  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !core_status.busy;

  mi_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .value_i     (in_i.value),
    .modulus_i   (mod_q),
    .res_ready_i (out_free),
    .status_o    (core_status),
    .inverse_o   (core_inv)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (core_status.res_valid && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= ModW'(2);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_status.res_valid && out_free) begin
      out_inv_q <= core_inv;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.inverse = out_inv_q;

  `MI_ASSERT_NXT(a_busy_after_accept, in_acc, !in_i.ready, "ready high after accept")
  `MI_ASSERT_IMP(a_inv_in_range, out_valid_q && (mod_q != '0), out_inv_q < mod_q, "bad inverse")
  `MI_ASSERT_NXT(a_result_moves, core_status.res_valid && !out_valid_q, out_valid_q, "result not registered")
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for modular_inverse: directed table, then random moduli and values.
// Depends on mi_pkg, mi_in_if, mi_out_if and the modular_inverse RTL; predicts each inverse not
// given in the directed table by extended Euclid and compares each output transaction in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mi_pkg::*;

  localparam logic [DataW-1:0] VAL_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataW-1:0] VAL_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [DataW-1:0] VAL_NEG_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [ModW-1:0]  MERSENNE_61 = 62'h1FFF_FFFF_FFFF_FFFF;
  localparam logic [ModW-1:0]  ALL_ONES_62 = 62'h3FFF_FFFF_FFFF_FFFF;
  localparam int               NUM_ROWS    = 24;

  typedef struct packed {
    logic [ModW-1:0]  modulus;
    logic [DataW-1:0] value;
    logic             known;
    logic [ModW-1:0]  inverse;
  } dir_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [ModW-1:0] cfg_wdata_i;

  mi_in_if  in_ch ();
  mi_out_if out_ch ();

  modular_inverse uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  logic [ModW-1:0] expected_inverses [$];
  logic [ModW-1:0] cur_modulus;
  int              tx_idle_pct;
  int              rx_idle_pct;
  int              rx_hold_left;
  int              fail_count;
  int              sent_count;
  int              checked_count;
  int              modulus_loads;

  dir_row_t dir_rows [0:NUM_ROWS-1] = '{
    '{62'd2, 64'd0,       1'b1, 62'd0},
    '{62'd2, 64'd1,       1'b1, 62'd1},
    '{62'd2, VAL_NEG_ONE, 1'b1, 62'd1},
    '{62'd2, VAL_MAX,     1'b1, 62'd1},
    '{62'd2, VAL_MIN,     1'b1, 62'd0},
    '{62'd7, 64'd3,       1'b1, 62'd5},
    '{62'd7, -64'sd3,     1'b1, 62'd2},
    '{62'd7, 64'd14,      1'b1, 62'd0},
    '{62'd7, -64'sd7,     1'b1, 62'd0},
    '{MERSENNE_61, 64'd2,       1'b1, 62'h1000_0000_0000_0000},
    '{MERSENNE_61, VAL_NEG_ONE, 1'b1, 62'h1FFF_FFFF_FFFF_FFFE},
    '{MERSENNE_61, VAL_MAX,     1'b0, 62'd0},
    '{MERSENNE_61, VAL_MIN,     1'b0, 62'd0},
    '{MERSENNE_61, 64'd12345,   1'b0, 62'd0},
    '{ALL_ONES_62, 64'd3,       1'b0, 62'd0},
    '{ALL_ONES_62, VAL_MIN,     1'b0, 62'd0},
    '{ALL_ONES_62, 64'd1,       1'b1, 62'd1},
    '{ALL_ONES_62, VAL_NEG_ONE, 1'b1, 62'h3FFF_FFFF_FFFF_FFFE},
    '{62'd6, 64'd4,       1'b0, 62'd0},
    '{62'd6, 64'd9,       1'b0, 62'd0},
    '{62'd1, 64'd5,       1'b1, 62'd0},
    '{62'd1, VAL_MIN,     1'b1, 62'd0},
    '{62'd0, 64'd12345,   1'b1, 62'd0},
    '{62'd0, VAL_NEG_ONE, 1'b1, 62'd0}
  };

  function automatic logic [DataW-1:0] residue_of(logic [DataW-1:0] x, logic [DataW-1:0] m);
    logic [DataW-1:0] rem;
    if (!x[DataW-1]) begin
      return x % m;
    end
    rem = (64'd0 - x) % m;
    return (rem != 0) ? m - rem : '0;
  endfunction

  function automatic logic [ModW-1:0] predict_inverse(logic [DataW-1:0] v,
                                                      logic [ModW-1:0] m_reg);
    logic [DataW-1:0] m, ra, rb, ta, tb, q, nr, nt, res;
    m = {2'b00, m_reg};
    if (m == 0) begin
      return '0;
    end
    ra = m;
    rb = residue_of(v, m);
    ta = '0;
    tb = 64'd1;
    while (rb != 0) begin
      q  = ra / rb;
      nr = ra - q * rb;
      nt = ta - q * tb;
      ra = rb;
      rb = nr;
      ta = tb;
      tb = nt;
    end
    res = residue_of(ta, m);
    return res[ModW-1:0];
  endfunction

  function automatic logic [ModW-1:0] pick_modulus(int stage, int ph);
    logic [DataW-1:0] r;
    r = {$urandom(), $urandom()};
    case (ph)
      0: r = 64'($urandom_range(1000, 3));
      1: r = {32'd0, r[31:0]};
      2: r = 64'(MERSENNE_61);
      3: r = {2'b00, r[ModW-1:0]};
      default: r = (stage == 0) ? 64'd2 : (stage == 1) ? 64'(ALL_ONES_62) : 64'd3;
    endcase
    if (r < 2) begin
      r = 64'd2;
    end
    return r[ModW-1:0];
  endfunction

  function automatic logic [DataW-1:0] random_value(logic [ModW-1:0] m_reg);
    logic [DataW-1:0] r, k, m;
    r = {$urandom(), $urandom()};
    k = {{54{r[9]}}, r[9:0]};
    m = {2'b00, m_reg};
    case ($urandom_range(7))
      3: return k;
      4: return k * m;
      5: return r[10] ? k * m + 64'd1 : k * m - 64'd1;
      6: begin
        case (r[1:0])
          2'd0: return VAL_MIN;
          2'd1: return VAL_MAX;
          2'd2: return '0;
          default: return VAL_NEG_ONE;
        endcase
      end
      7: return {{32{r[31]}}, r[31:0]};
      default: return r;
    endcase
  endfunction

  task automatic send_value(input logic [DataW-1:0] v, input logic [ModW-1:0] exp_inv);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_inverses.push_back(exp_inv);
    sent_count++;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_inverses.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_modulus(input logic [ModW-1:0] m);
    wait_for_results();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_modulus = m;
    modulus_loads++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("modular_inverse test failed");
    $finish;
  end

  initial begin : result_checker
    logic [ModW-1:0] exp_inv;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_inverses.size() == 0) begin
          $error("unexpected transaction: inverse %h with nothing pending", out_ch.inverse);
          fail_count++;
        end else begin
          exp_inv = expected_inverses.pop_front();
          checked_count++;
          if (out_ch.inverse !== exp_inv) begin
            $error("inverse mismatch: expected %h, actual %h", exp_inv, out_ch.inverse);
            fail_count++;
          end
        end
      end
      if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [DataW-1:0] v;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    cur_modulus   = 62'd2;
    tx_idle_pct   = 33;
    rx_idle_pct   = 74;
    rx_hold_left  = 0;
    fail_count    = 0;
    sent_count    = 0;
    checked_count = 0;
    modulus_loads = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].modulus != cur_modulus) begin
        load_modulus(dir_rows[i].modulus);
      end
      send_value(dir_rows[i].value, dir_rows[i].known ? dir_rows[i].inverse :
                 predict_inverse(dir_rows[i].value, cur_modulus));
    end

    for (int stage = 0; stage < 3; stage++) begin
      tx_idle_pct = (stage == 0) ? 33 : (stage == 1) ? 74 : 0;
      rx_idle_pct = (stage == 0) ? 74 : (stage == 1) ? 33 : 0;
      for (int ph = 0; ph < 5; ph++) begin
        load_modulus(pick_modulus(stage, ph));
        for (int n = 0; n < 100; n++) begin
          // stall the output long enough to back up the input
          if (stage == 0 && ph == 1 && n == 20) begin
            rx_hold_left = 2500;
          end
          if (stage == 1 && ph == 2 && n == 50) begin
            wait_for_results();
          end
          v = random_value(cur_modulus);
          send_value(v, predict_inverse(v, cur_modulus));
        end
      end
    end

    wait_for_results();
    repeat (800) @(posedge clk_i);
    $display("sent %0d values, checked %0d inverses over %0d modulus loads",
             sent_count, checked_count, modulus_loads);
    $display("covered moduli 0, 1, 2, small, 32-bit, 2^61-1, 2^62-1 and random 62-bit");
    if (fail_count == 0) begin
      $display("modular_inverse test passed");
    end else begin
      $display("modular_inverse test failed");
    end
    $finish;
  end

endmodule
